// File: rtl/trpf_pkg.sv
// ----------------------------------------------------------------------------
// trpf_pkg
// Shared types and constants of the touch region pass filter.
// ----------------------------------------------------------------------------
package trpf_pkg;

    localparam int REGIONS_DEF    = 10;
    localparam int POINT_IDS_DEF  = 32;
    localparam int COORD_BITS_DEF = 16;
    localparam int QUEUE_DEPTH    = 2;

    localparam int ACTION_W  = 2;
    localparam int ID_W      = 5;
    localparam int STATUS_W  = 8;
    localparam int RIDX_W    = 4;
    localparam int CODE_W    = 4;
    localparam int CFG_IDX_W = 3;

    localparam int Y_OFFSET_RST     = 0;
    localparam int TOUCH_WIDTH_RST  = 32767;
    localparam int TOUCH_HEIGHT_RST = 32767;
    localparam logic [CODE_W-1:0] DOWN_CODE_RST = 4'd1;
    localparam logic [CODE_W-1:0] UP_CODE_RST   = 4'd0;

    typedef enum logic [ACTION_W-1:0] {
        ACT_POINT      = 2'd0,
        ACT_SET_REGION = 2'd1,
        ACT_CLR_REGION = 2'd2,
        ACT_CLR_LATCH  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        LATCH_NONE    = 2'd0,
        LATCH_BLOCKED = 2'd1,
        LATCH_FORWARD = 2'd2
    } t_latch;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_Y_OFFSET     = 3'd0,
        CFG_TOUCH_WIDTH  = 3'd1,
        CFG_TOUCH_HEIGHT = 3'd2,
        CFG_DOWN_CODE    = 3'd3,
        CFG_UP_CODE      = 3'd4
    } t_cfg_reg;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_EXEC = 2'd1,
        BK_WALK = 2'd2
    } t_back_state;

    // classification of one queued item
    typedef struct packed {
        t_action op;
        logic    is_down;
        logic    is_up;
        logic    ridx_ok;
    } t_ctl;

endpackage

// File: rtl/touch_region_pass_filter.sv
// ----------------------------------------------------------------------------
// touch_region_pass_filter
// Touch point pass filter with exclusion regions and per-id latches.
// ----------------------------------------------------------------------------
// Usage:
//   An item is taken on a rising edge with i_start high and o_busy low. Items
//   enter a two-entry queue; o_busy is high while that queue is full.
//   Action 0 is a touch point, 1 sets a region, 2 clears a region and 3
//   clears all point latches. Only ups and forwarded points give a result.
//   A result is shown for one cycle with o_out_valid high; there is no
//   backpressure on the result side.
//   Before its strobe an item passes the queue, the item registers and the
//   result register; for the first down of an id the back end also walks
//   the region table one region per cycle. The back end takes the next item
//   only once it is back in idle. Configuration writes (i_cfg_we,
//   i_cfg_index, i_cfg_wdata) take effect at the next edge; the user must
//   make them while no item is in flight, as the block does not enforce it.
//   Reset clears the queue, all region valid bits and all point latches, and
//   loads the register reset values.
// ----------------------------------------------------------------------------
module touch_region_pass_filter
    import trpf_pkg::*;
#(
    parameter int REGIONS    = REGIONS_DEF,
    parameter int POINT_IDS  = POINT_IDS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [ID_W-1:0]       i_point_id,
    input  logic [STATUS_W-1:0]   i_point_status,
    input  logic [RIDX_W-1:0]     i_region_index,
    input  logic [COORD_BITS-1:0] i_coord_x,
    input  logic [COORD_BITS-1:0] i_coord_y,
    input  logic [COORD_BITS-1:0] i_region_w,
    input  logic [COORD_BITS-1:0] i_region_h,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [COORD_BITS-1:0] i_cfg_wdata,
    output logic                  o_out_valid,
    output logic [ID_W-1:0]       o_out_id,
    output logic [STATUS_W-1:0]   o_out_status,
    output logic [COORD_BITS-1:0] o_out_x,
    output logic [COORD_BITS-1:0] o_out_y
);

    localparam int REG_IDX_BITS = (REGIONS > 1) ? $clog2(REGIONS) : 1;
    localparam int SLOT_BITS    = $clog2(POINT_IDS);
    localparam int CTL_W        = $bits(t_ctl);
    localparam int ENTRY_W      = CTL_W + ID_W + STATUS_W + SLOT_BITS + REG_IDX_BITS
                                  + 4 * COORD_BITS;

    t_ctl                    f_ctl;
    logic [SLOT_BITS-1:0]    f_slot;
    logic [REG_IDX_BITS-1:0] f_ridx;
    logic [COORD_BITS-1:0]   f_right;
    logic [COORD_BITS-1:0]   f_bottom;
    logic [COORD_BITS-1:0]   cfg_y_offset;
    logic [COORD_BITS-1:0]   cfg_touch_width;
    logic [COORD_BITS-1:0]   cfg_touch_height;

    logic                    q_push;
    logic                    q_pop;
    logic                    q_empty;
    logic                    q_full;
    logic [ENTRY_W-1:0]      q_wdata;
    logic [ENTRY_W-1:0]      q_rdata;

    t_ctl                    b_ctl;
    logic [ID_W-1:0]         b_id;
    logic [STATUS_W-1:0]     b_status;
    logic [SLOT_BITS-1:0]    b_slot;
    logic [REG_IDX_BITS-1:0] b_ridx;
    logic [COORD_BITS-1:0]   b_x;
    logic [COORD_BITS-1:0]   b_y;
    logic [COORD_BITS-1:0]   b_right;
    logic [COORD_BITS-1:0]   b_bottom;

    trpf_front #(
        .REGIONS      (REGIONS),
        .POINT_IDS    (POINT_IDS),
        .COORD_BITS   (COORD_BITS),
        .REG_IDX_BITS (REG_IDX_BITS),
        .SLOT_BITS    (SLOT_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_action       (i_action),
        .i_point_id     (i_point_id),
        .i_point_status (i_point_status),
        .i_region_index (i_region_index),
        .i_coord_x      (i_coord_x),
        .i_coord_y      (i_coord_y),
        .i_region_w     (i_region_w),
        .i_region_h     (i_region_h),
        .o_ctl          (f_ctl),
        .o_slot         (f_slot),
        .o_ridx         (f_ridx),
        .o_right        (f_right),
        .o_bottom       (f_bottom),
        .o_y_offset     (cfg_y_offset),
        .o_touch_width  (cfg_touch_width),
        .o_touch_height (cfg_touch_height)
    );

    assign o_busy  = q_full;
    assign q_push  = i_start && !q_full;
    assign q_wdata = {f_ctl, i_point_id, i_point_status, f_slot, f_ridx,
                      i_coord_x, i_coord_y, f_right, f_bottom};

    trpf_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_wdata (q_wdata),
        .i_pop   (q_pop),
        .o_rdata (q_rdata),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    assign {b_ctl, b_id, b_status, b_slot, b_ridx, b_x, b_y, b_right, b_bottom} = q_rdata;

    trpf_back #(
        .REGIONS      (REGIONS),
        .POINT_IDS    (POINT_IDS),
        .COORD_BITS   (COORD_BITS),
        .REG_IDX_BITS (REG_IDX_BITS),
        .SLOT_BITS    (SLOT_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .o_pop          (q_pop),
        .i_ctl          (b_ctl),
        .i_id           (b_id),
        .i_status       (b_status),
        .i_slot         (b_slot),
        .i_ridx         (b_ridx),
        .i_x            (b_x),
        .i_y            (b_y),
        .i_right        (b_right),
        .i_bottom       (b_bottom),
        .i_y_offset     (cfg_y_offset),
        .i_touch_width  (cfg_touch_width),
        .i_touch_height (cfg_touch_height),
        .o_out_valid    (o_out_valid),
        .o_out_id       (o_out_id),
        .o_out_status   (o_out_status),
        .o_out_x        (o_out_x),
        .o_out_y        (o_out_y)
    );

endmodule

// File: rtl/trpf_front.sv
// ----------------------------------------------------------------------------
// trpf_front
// Configuration registers and item classification ahead of the queue.
// ----------------------------------------------------------------------------
module trpf_front
    import trpf_pkg::*;
#(
    parameter int REGIONS    = REGIONS_DEF,
    parameter int POINT_IDS  = POINT_IDS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int REG_IDX_BITS = (REGIONS > 1) ? $clog2(REGIONS) : 1,
    parameter int SLOT_BITS    = $clog2(POINT_IDS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [COORD_BITS-1:0]   i_cfg_wdata,
    input  logic [ACTION_W-1:0]     i_action,
    input  logic [ID_W-1:0]         i_point_id,
    input  logic [STATUS_W-1:0]     i_point_status,
    input  logic [RIDX_W-1:0]       i_region_index,
    input  logic [COORD_BITS-1:0]   i_coord_x,
    input  logic [COORD_BITS-1:0]   i_coord_y,
    input  logic [COORD_BITS-1:0]   i_region_w,
    input  logic [COORD_BITS-1:0]   i_region_h,
    output t_ctl                    o_ctl,
    output logic [SLOT_BITS-1:0]    o_slot,
    output logic [REG_IDX_BITS-1:0] o_ridx,
    output logic [COORD_BITS-1:0]   o_right,
    output logic [COORD_BITS-1:0]   o_bottom,
    output logic [COORD_BITS-1:0]   o_y_offset,
    output logic [COORD_BITS-1:0]   o_touch_width,
    output logic [COORD_BITS-1:0]   o_touch_height
);

    localparam int LUT_N = 2 ** ID_W;

    logic [COORD_BITS-1:0] r_y_offset;
    logic [COORD_BITS-1:0] r_touch_width;
    logic [COORD_BITS-1:0] r_touch_height;
    logic [CODE_W-1:0]     r_down_code;
    logic [CODE_W-1:0]     r_up_code;

    logic [SLOT_BITS-1:0]  w_slot_lut [LUT_N];
    logic [CODE_W-1:0]     w_nibble;
    logic [COORD_BITS:0]   w_right_sum;
    logic [COORD_BITS:0]   w_bottom_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_y_offset     <= COORD_BITS'(Y_OFFSET_RST);
            r_touch_width  <= COORD_BITS'(TOUCH_WIDTH_RST);
            r_touch_height <= COORD_BITS'(TOUCH_HEIGHT_RST);
            r_down_code    <= DOWN_CODE_RST;
            r_up_code      <= UP_CODE_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                CFG_Y_OFFSET:     r_y_offset     <= i_cfg_wdata;
                CFG_TOUCH_WIDTH:  r_touch_width  <= i_cfg_wdata;
                CFG_TOUCH_HEIGHT: r_touch_height <= i_cfg_wdata;
                CFG_DOWN_CODE:    r_down_code    <= i_cfg_wdata[CODE_W-1:0];
                CFG_UP_CODE:      r_up_code      <= i_cfg_wdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // id to latch slot, modulo the slot count
    for (genvar g = 0; g < LUT_N; g++) begin : g_slot
        assign w_slot_lut[g] = SLOT_BITS'(g % POINT_IDS);
    end

    assign w_nibble     = i_point_status[CODE_W-1:0];
    assign w_right_sum  = {1'b0, i_coord_x} + {1'b0, i_region_w};
    assign w_bottom_sum = {1'b0, i_coord_y} + {1'b0, i_region_h};

    always_comb begin
        o_ctl.op      = t_action'(i_action);
        o_ctl.is_down = (w_nibble == r_down_code);
        o_ctl.is_up   = (w_nibble != r_down_code) && (w_nibble == r_up_code);
        o_ctl.ridx_ok = (32'(i_region_index) < REGIONS);
    end

    assign o_slot   = w_slot_lut[i_point_id];
    assign o_ridx   = REG_IDX_BITS'(i_region_index);
    assign o_right  = w_right_sum[COORD_BITS] ? '1 : w_right_sum[COORD_BITS-1:0];
    assign o_bottom = w_bottom_sum[COORD_BITS] ? '1 : w_bottom_sum[COORD_BITS-1:0];

    assign o_y_offset     = r_y_offset;
    assign o_touch_width  = r_touch_width;
    assign o_touch_height = r_touch_height;

endmodule

// File: rtl/trpf_queue.sv
// ----------------------------------------------------------------------------
// trpf_queue
// Short register FIFO between the front and the back.
// ----------------------------------------------------------------------------
module trpf_queue
    import trpf_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_empty,
    output logic             o_full
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wptr;
    logic [PTR_BITS-1:0] r_rptr;
    logic [CNT_BITS-1:0] r_count;
    logic [PTR_BITS-1:0] n_wptr;
    logic [PTR_BITS-1:0] n_rptr;

    assign n_wptr = (r_wptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
    assign n_rptr = (r_rptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= n_wptr;
            end
            if (i_pop) begin
                r_rptr <= n_rptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CNT_BITS'(DEPTH));

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("queue read while empty");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(DEPTH))
        else $error("queue count out of range");

endmodule

// File: rtl/trpf_back.sv
// ----------------------------------------------------------------------------
// trpf_back
// Region table, point latches, region walk and result formatting.
// ----------------------------------------------------------------------------
module trpf_back
    import trpf_pkg::*;
#(
    parameter int REGIONS    = REGIONS_DEF,
    parameter int POINT_IDS  = POINT_IDS_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int REG_IDX_BITS = (REGIONS > 1) ? $clog2(REGIONS) : 1,
    parameter int SLOT_BITS    = $clog2(POINT_IDS)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_q_empty,
    output logic                    o_pop,
    input  t_ctl                    i_ctl,
    input  logic [ID_W-1:0]         i_id,
    input  logic [STATUS_W-1:0]     i_status,
    input  logic [SLOT_BITS-1:0]    i_slot,
    input  logic [REG_IDX_BITS-1:0] i_ridx,
    input  logic [COORD_BITS-1:0]   i_x,
    input  logic [COORD_BITS-1:0]   i_y,
    input  logic [COORD_BITS-1:0]   i_right,
    input  logic [COORD_BITS-1:0]   i_bottom,
    input  logic [COORD_BITS-1:0]   i_y_offset,
    input  logic [COORD_BITS-1:0]   i_touch_width,
    input  logic [COORD_BITS-1:0]   i_touch_height,
    output logic                    o_out_valid,
    output logic [ID_W-1:0]         o_out_id,
    output logic [STATUS_W-1:0]     o_out_status,
    output logic [COORD_BITS-1:0]   o_out_x,
    output logic [COORD_BITS-1:0]   o_out_y
);

    t_back_state r_state;
    t_back_state n_state;

    t_ctl                    r_cur_ctl;
    logic [ID_W-1:0]         r_cur_id;
    logic [STATUS_W-1:0]     r_cur_status;
    logic [SLOT_BITS-1:0]    r_cur_slot;
    logic [REG_IDX_BITS-1:0] r_cur_ridx;
    logic [COORD_BITS-1:0]   r_cur_x;
    logic [COORD_BITS-1:0]   r_cur_y;
    logic [COORD_BITS-1:0]   r_cur_right;
    logic [COORD_BITS-1:0]   r_cur_bottom;

    logic                    r_rvalid [REGIONS];
    logic [COORD_BITS-1:0]   r_left   [REGIONS];
    logic [COORD_BITS-1:0]   r_top    [REGIONS];
    logic [COORD_BITS-1:0]   r_right  [REGIONS];
    logic [COORD_BITS-1:0]   r_bottom [REGIONS];
    t_latch                  r_latch  [POINT_IDS];

    logic [REG_IDX_BITS-1:0] r_walk;
    logic                    r_hit;

    logic                    r_out_valid;
    logic [ID_W-1:0]         r_out_id;
    logic [STATUS_W-1:0]     r_out_status;
    logic [COORD_BITS-1:0]   r_out_x;
    logic [COORD_BITS-1:0]   r_out_y;

    t_latch                  latch_rd;
    logic                    walk_last;
    logic                    region_hit;
    logic                    first_down;
    logic                    walk_start;
    logic                    latch_we;
    t_latch                  latch_val;
    logic                    latch_clr_all;
    logic                    region_set;
    logic                    region_clr;
    logic                    emit;
    logic [COORD_BITS-1:0]   fmt_x;
    logic [COORD_BITS-1:0]   fmt_y;
    logic [COORD_BITS-1:0]   dy;

    assign latch_rd   = r_latch[r_cur_slot];
    assign walk_last  = (r_walk == REG_IDX_BITS'(REGIONS - 1));
    assign region_hit = r_rvalid[r_walk] &&
                        (r_left[r_walk] <= r_cur_x) && (r_cur_x <= r_right[r_walk]) &&
                        (r_top[r_walk] <= r_cur_y) && (r_cur_y <= r_bottom[r_walk]);
    assign first_down = (r_cur_ctl.op == ACT_POINT) && r_cur_ctl.is_down &&
                        (latch_rd == LATCH_NONE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = BK_EXEC;
                end
            end
            BK_EXEC: begin
                n_state = first_down ? BK_WALK : BK_IDLE;
            end
            BK_WALK: begin
                if (walk_last) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop         = 1'b0;
        walk_start    = 1'b0;
        latch_we      = 1'b0;
        latch_val     = LATCH_NONE;
        latch_clr_all = 1'b0;
        region_set    = 1'b0;
        region_clr    = 1'b0;
        emit          = 1'b0;
        case (r_state)
            BK_IDLE: begin
                o_pop = !i_q_empty;
            end
            BK_EXEC: begin
                case (r_cur_ctl.op)
                    ACT_POINT: begin
                        if (r_cur_ctl.is_down) begin
                            walk_start = (latch_rd == LATCH_NONE);
                            emit       = (latch_rd == LATCH_FORWARD);
                        end else if (r_cur_ctl.is_up) begin
                            latch_we = 1'b1;
                            emit     = 1'b1;
                        end else begin
                            latch_we = 1'b1;
                            emit     = (latch_rd == LATCH_FORWARD);
                        end
                    end
                    ACT_SET_REGION: region_set    = r_cur_ctl.ridx_ok;
                    ACT_CLR_REGION: region_clr    = r_cur_ctl.ridx_ok;
                    ACT_CLR_LATCH:  latch_clr_all = 1'b1;
                    default: ;
                endcase
            end
            BK_WALK: begin
                if (walk_last) begin
                    latch_we  = 1'b1;
                    latch_val = (r_hit || region_hit) ? LATCH_BLOCKED : LATCH_FORWARD;
                    emit      = !(r_hit || region_hit);
                end
            end
            default: ;
        endcase
    end

    assign fmt_x = (r_cur_x > i_touch_width) ? i_touch_width : r_cur_x;
    assign dy    = r_cur_y - i_y_offset;
    assign fmt_y = (r_cur_y < i_y_offset) ? '0 :
                   (dy > i_touch_height) ? i_touch_height : dy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_walk      <= '0;
            r_hit       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= emit;
            if (walk_start) begin
                r_walk <= '0;
                r_hit  <= 1'b0;
            end else if (r_state == BK_WALK) begin
                r_walk <= r_walk + 1'b1;
                r_hit  <= r_hit || region_hit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REGIONS; i++) begin
                r_rvalid[i] <= 1'b0;
            end
        end else if (region_set) begin
            r_rvalid[r_cur_ridx] <= 1'b1;
        end else if (region_clr) begin
            r_rvalid[r_cur_ridx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (region_set) begin
            r_left[r_cur_ridx]   <= r_cur_x;
            r_top[r_cur_ridx]    <= r_cur_y;
            r_right[r_cur_ridx]  <= r_cur_right;
            r_bottom[r_cur_ridx] <= r_cur_bottom;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || latch_clr_all) begin
            for (int i = 0; i < POINT_IDS; i++) begin
                r_latch[i] <= LATCH_NONE;
            end
        end else if (latch_we) begin
            r_latch[r_cur_slot] <= latch_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cur_ctl    <= i_ctl;
            r_cur_id     <= i_id;
            r_cur_status <= i_status;
            r_cur_slot   <= i_slot;
            r_cur_ridx   <= i_ridx;
            r_cur_x      <= i_x;
            r_cur_y      <= i_y;
            r_cur_right  <= i_right;
            r_cur_bottom <= i_bottom;
        end
        if (emit) begin
            r_out_id     <= r_cur_id;
            r_out_status <= r_cur_status;
            r_out_x      <= fmt_x;
            r_out_y      <= fmt_y;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_id     = r_out_id;
    assign o_out_status = r_out_status;
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;

    a_emit_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> ($past(r_state) == BK_EXEC || $past(r_state) == BK_WALK))
        else $error("result strobe without an item in work");

    a_walk_is_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_WALK) |-> (r_cur_ctl.op == ACT_POINT && r_cur_ctl.is_down))
        else $error("region walk for an item that is not a down");

    a_walk_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_WALK) |-> (32'(r_walk) < REGIONS))
        else $error("region walk index out of range");

    a_no_pop_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != BK_IDLE) |-> !o_pop)
        else $error("queue popped while an item is in work");

endmodule
